/* hw/rtl/spi_pkg.sv */
// ----------------------------------------------------------------------------
// Speed profile interpolator package
// Shared sizes, codes, item types and field helpers for the interpolator.
// ----------------------------------------------------------------------------
package spi_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int FRAC_BITS   = 16;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int QUO_W   = 32 + FRAC_BITS;
   localparam int ALPHA_W = FRAC_BITS + 1;
   localparam int DIVC_W  = $clog2(QUO_W);
   localparam int MUL_XW  = 34;
   localparam int MUL_YW  = 33;
   localparam int PROD_W  = MUL_XW + MUL_YW;
   localparam int WIDE_W  = 96;
   localparam int FLD_W   = 3;

   localparam logic [FLD_W-1:0] FLD_TIME  = 3'd0;
   localparam logic [FLD_W-1:0] FLD_DIST  = 3'd1;
   localparam logic [FLD_W-1:0] FLD_SPEED = 3'd2;
   localparam logic [FLD_W-1:0] FLD_ACCEL = 3'd3;
   localparam logic [FLD_W-1:0] FLD_JERK  = 3'd4;

   localparam logic CSR_XP_LIMIT  = 1'b0;
   localparam logic CSR_MIN_SPEED = 1'b1;

   localparam logic [30:0] XP_LIMIT_RST  = 31'd327680;
   localparam logic [30:0] MIN_SPEED_RST = 31'd65536;

   typedef enum logic [2:0] {
      CMD_CLEAR       = 3'd0,
      CMD_LOAD        = 3'd1,
      CMD_BY_TIME     = 3'd2,
      CMD_BY_TIME_XP  = 3'd3,
      CMD_BY_DIST     = 3'd4,
      CMD_BY_DIST_EXT = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_POINT = 2'd0,
      ST_NONE  = 2'd1,
      ST_DONE  = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_CHK_FIRST, S_CHK_LAST, S_SRCH_RD, S_SRCH_CMP, S_SRCH_END,
      S_SHIFT_RD, S_SHIFT_WR, S_INSERT, S_FETCH_LO, S_FETCH_HI, S_DIV, S_LERP_MUL,
      S_LERP_ADD, S_OUT_ROW, S_EXT_FIN, S_XP_MUL_A, S_XP_ADD_A, S_XP_MUL_V, S_XP_ADD_V,
      S_XP_MUL_L, S_XP_MUL_H, S_XP_SUM, S_XP_FIN
   } state_type;

   typedef struct packed {
      cmd_type            command;
      logic signed [31:0] in_time;
      logic signed [31:0] in_dist;
      logic signed [31:0] in_speed;
      logic signed [31:0] in_accel;
      logic signed [31:0] in_jerk;
      logic signed [31:0] query_value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] out_time;
      logic signed [31:0] out_dist;
      logic signed [31:0] out_speed;
      logic signed [31:0] out_accel;
      logic signed [31:0] out_jerk;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] p_time;
      logic signed [31:0] p_dist;
      logic signed [31:0] p_speed;
      logic signed [31:0] p_accel;
      logic signed [31:0] p_jerk;
   } point_type;

   function automatic logic signed [31:0] fld_get(input point_type p,
                                                 input logic [FLD_W-1:0] f);
      logic signed [31:0] r;
      case (f)
         FLD_TIME:  r = p.p_time;
         FLD_DIST:  r = p.p_dist;
         FLD_SPEED: r = p.p_speed;
         FLD_ACCEL: r = p.p_accel;
         default:   r = p.p_jerk;
      endcase
      return r;
   endfunction

   function automatic point_type fld_set(input point_type p, input logic [FLD_W-1:0] f,
                                         input logic signed [31:0] v);
      point_type r;
      r = p;
      case (f)
         FLD_TIME:  r.p_time  = v;
         FLD_DIST:  r.p_dist  = v;
         FLD_SPEED: r.p_speed = v;
         FLD_ACCEL: r.p_accel = v;
         default:   r.p_jerk  = v;
      endcase
      return r;
   endfunction

   function automatic logic signed [WIDE_W-1:0] sx32(input logic signed [31:0] v);
      return {{(WIDE_W-32){v[31]}}, v};
   endfunction

   function automatic logic signed [WIDE_W-1:0] sxprod(input logic signed [PROD_W-1:0] v);
      return {{(WIDE_W-PROD_W){v[PROD_W-1]}}, v};
   endfunction

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [31:0] r;
      if (v > sx32(32'sh7FFF_FFFF)) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < sx32(32'sh8000_0000)) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/speed_profile_interpolator.sv */
// ----------------------------------------------------------------------------
// Speed profile interpolator
// Sorted table of speed points with time/distance lookup by binary search,
// linear interpolation, and extrapolation or extension past the last point.
// ----------------------------------------------------------------------------
// Order of work: a load runs the search, then moves entries up one at a time;
//   a query runs the search, the divider and one multiply and one add per field;
//   extrapolation runs its products one at a time after the range checks.
// Throughput: one item at a time; busy stays high until its result has gone.
// Table traffic uses one read and one write port; all products go through one
//   34x33 multiplier; quotients through one radix-2 divider (48 steps).
// Reset: synchronous; empties the table and restores both registers.
// The result strobe lasts one cycle and cannot be stalled.
module speed_profile_interpolator (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  spi_pkg::req_type req_data,
   output logic            rsp_valid,
   output spi_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_index,
   input  logic [31:0]     csr_wdata
);

   // control state
   spi_pkg::state_type state_ff, state_in;
   logic [spi_pkg::CNT_W-1:0] count_ff, count_in;
   logic [30:0] limit_ff, minspd_ff;
   logic rsp_valid_ff, rsp_valid_in;

   // payload
   spi_pkg::req_type   req_ff, req_in;
   spi_pkg::rsp_type   rsp_ff, rsp_in;
   spi_pkg::point_type lo_ff, lo_in, hi_ff, hi_in, pt_ff, pt_in;
   logic [spi_pkg::CNT_W-1:0] first_ff, first_in, len_ff, len_in, k_ff, k_in;
   logic [31:0] rem_ff, rem_in, dvsr_ff, dvsr_in;
   logic [spi_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [spi_pkg::DIVC_W-1:0] divc_ff, divc_in;
   logic ext_ff, ext_in;
   logic [30:0] d_ff, d_in;
   logic signed [62:0] p_ff, p_in;
   logic signed [spi_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [spi_pkg::WIDE_W-1:0] wide_ff, wide_in, acc_ff, acc_in;
   logic [spi_pkg::FLD_W-1:0] fld_ff, fld_in;

   // table memory, one row per point
   spi_pkg::point_type mem [spi_pkg::TABLE_DEPTH];
   spi_pkg::point_type rd_row_ff, wr_row;
   logic [spi_pkg::IDX_W-1:0] rd_addr, wr_addr;
   logic wr_en;

   // working signals
   logic signed [spi_pkg::MUL_XW-1:0] mul_x;
   logic signed [spi_pkg::MUL_YW-1:0] mul_y;
   logic emit;
   spi_pkg::status_type emit_status;
   spi_pkg::point_type emit_pt, lerp_pt;
   logic by_dist, is_load, go_right, v_pos, div_ge;
   logic signed [31:0] q, key_row, srch_key, a_f, b_f, v_min, v_sel, lerp_v;
   logic [spi_pkg::CNT_W-1:0] last_w, half_w, mid_w, km1_w, im1_w;
   logic [32:0] d_w, ext_diff, lo_diff, den_w, rem_sh, rem_sub;
   logic [32:0] b_sub;
   logic signed [spi_pkg::WIDE_W-1:0] wsum;

   assign busy      = (state_ff != spi_pkg::S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Memory: one write, one registered read each cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      rd_row_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spi_pkg::S_IDLE;
         count_ff     <= '0;
         limit_ff     <= spi_pkg::XP_LIMIT_RST;
         minspd_ff    <= spi_pkg::MIN_SPEED_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               spi_pkg::CSR_XP_LIMIT:  limit_ff  <= csr_wdata[30:0];
               spi_pkg::CSR_MIN_SPEED: minspd_ff <= csr_wdata[30:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      pt_ff    <= pt_in;
      first_ff <= first_in;
      len_ff   <= len_in;
      k_ff     <= k_in;
      rem_ff   <= rem_in;
      dvsr_ff  <= dvsr_in;
      quo_ff   <= quo_in;
      divc_ff  <= divc_in;
      ext_ff   <= ext_in;
      d_ff     <= d_in;
      p_ff     <= p_in;
      prod_ff  <= prod_in;
      wide_ff  <= wide_in;
      acc_ff   <= acc_in;
      fld_ff   <= fld_in;
   end

   // shared datapath pieces
   assign q        = req_ff.query_value;
   assign is_load  = (req_ff.command == spi_pkg::CMD_LOAD);
   assign by_dist  = (req_ff.command == spi_pkg::CMD_BY_DIST) ||
                     (req_ff.command == spi_pkg::CMD_BY_DIST_EXT);
   assign key_row  = by_dist ? rd_row_ff.p_dist : rd_row_ff.p_time;
   assign srch_key = is_load ? rd_row_ff.p_time : key_row;
   assign go_right = is_load ? (srch_key <= req_ff.in_time) : (srch_key < q);
   assign last_w   = count_ff - 1'b1;
   assign half_w   = len_ff >> 1;
   assign mid_w    = first_ff + half_w;
   assign km1_w    = k_ff - 1'b1;
   assign im1_w    = first_ff - 1'b1;
   assign d_w      = {q[31], q} - {rd_row_ff.p_time[31], rd_row_ff.p_time};
   assign ext_diff = {q[31], q} - {rd_row_ff.p_dist[31], rd_row_ff.p_dist};
   assign lo_diff  = {q[31], q} - (by_dist ? {lo_ff.p_dist[31], lo_ff.p_dist}
                                           : {lo_ff.p_time[31], lo_ff.p_time});
   assign den_w    = {key_row[31], key_row} - (by_dist ? {lo_ff.p_dist[31], lo_ff.p_dist}
                                                       : {lo_ff.p_time[31], lo_ff.p_time});
   assign v_min    = $signed({1'b0, minspd_ff});
   assign v_sel    = (rd_row_ff.p_speed > v_min) ? rd_row_ff.p_speed : v_min;
   assign v_pos    = !v_sel[31] && (v_sel != 32'sd0);
   assign rem_sh   = {rem_ff, quo_ff[spi_pkg::QUO_W-1]};
   assign rem_sub  = rem_sh - {1'b0, dvsr_ff};
   assign div_ge   = (rem_sh >= {1'b0, dvsr_ff});
   assign a_f      = spi_pkg::fld_get(lo_ff, fld_ff);
   assign b_f      = spi_pkg::fld_get(hi_ff, fld_ff);
   assign b_sub    = {b_f[31], b_f} - {a_f[31], a_f};
   assign lerp_v   = spi_pkg::sat32(spi_pkg::sx32(a_f) +
                                    spi_pkg::sxprod(prod_ff >>> spi_pkg::FRAC_BITS));
   assign lerp_pt  = spi_pkg::fld_set(pt_ff, fld_ff, lerp_v);
   assign prod_in  = mul_x * mul_y;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      req_in      = req_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      pt_in       = pt_ff;
      first_in    = first_ff;
      len_in      = len_ff;
      k_in        = k_ff;
      rem_in      = rem_ff;
      dvsr_in     = dvsr_ff;
      quo_in      = quo_ff;
      divc_in     = divc_ff;
      ext_in      = ext_ff;
      d_in        = d_ff;
      p_in        = p_ff;
      wide_in     = wide_ff;
      acc_in      = acc_ff;
      fld_in      = fld_ff;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_row      = '0;
      mul_x       = '0;
      mul_y       = '0;
      emit        = 1'b0;
      emit_status = spi_pkg::ST_NONE;
      emit_pt     = '0;
      wsum        = '0;

      case (state_ff)
         spi_pkg::S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = spi_pkg::S_DISPATCH;
            end
         end

         spi_pkg::S_DISPATCH: begin
            case (req_ff.command)
               spi_pkg::CMD_CLEAR: begin
                  count_in    = '0;
                  emit        = 1'b1;
                  emit_status = spi_pkg::ST_DONE;
               end
               spi_pkg::CMD_LOAD: begin
                  if (count_ff == spi_pkg::CNT_W'(spi_pkg::TABLE_DEPTH)) begin
                     emit        = 1'b1;
                     emit_status = spi_pkg::ST_FULL;
                  end else begin
                     first_in = '0;
                     len_in   = count_ff;
                     state_in = spi_pkg::S_SRCH_RD;
                  end
               end
               spi_pkg::CMD_BY_TIME, spi_pkg::CMD_BY_TIME_XP,
               spi_pkg::CMD_BY_DIST, spi_pkg::CMD_BY_DIST_EXT: begin
                  if (count_ff < spi_pkg::CNT_W'(2)) begin
                     emit = 1'b1;
                  end else begin
                     rd_addr  = '0;
                     state_in = spi_pkg::S_CHK_FIRST;
                  end
               end
               default: emit = 1'b1;
            endcase
         end

         // drop queries below the first key, then fetch the last point
         spi_pkg::S_CHK_FIRST: begin
            if (q < key_row) begin
               emit = 1'b1;
            end else begin
               rd_addr  = last_w[spi_pkg::IDX_W-1:0];
               state_in = spi_pkg::S_CHK_LAST;
            end
         end

         spi_pkg::S_CHK_LAST: begin
            hi_in = rd_row_ff;
            if (q > key_row) begin
               case (req_ff.command)
                  spi_pkg::CMD_BY_TIME_XP: begin
                     if (d_w > {2'b00, limit_ff}) begin
                        emit = 1'b1;
                     end else begin
                        d_in     = d_w[30:0];
                        state_in = spi_pkg::S_XP_MUL_A;
                     end
                  end
                  spi_pkg::CMD_BY_DIST_EXT: begin
                     if (!v_pos) begin
                        emit = 1'b1;
                     end else begin
                        pt_in.p_speed = v_sel;
                        quo_in   = {ext_diff[31:0], {spi_pkg::FRAC_BITS{1'b0}}};
                        rem_in   = '0;
                        dvsr_in  = v_sel;
                        divc_in  = '0;
                        ext_in   = 1'b1;
                        state_in = spi_pkg::S_DIV;
                     end
                  end
                  default: emit = 1'b1;
               endcase
            end else begin
               first_in = '0;
               len_in   = count_ff;
               state_in = spi_pkg::S_SRCH_RD;
            end
         end

         // binary search: probe the middle entry, halve the range
         spi_pkg::S_SRCH_RD: begin
            if (len_ff == '0) begin
               state_in = spi_pkg::S_SRCH_END;
            end else begin
               rd_addr  = mid_w[spi_pkg::IDX_W-1:0];
               state_in = spi_pkg::S_SRCH_CMP;
            end
         end

         spi_pkg::S_SRCH_CMP: begin
            if (go_right) begin
               first_in = mid_w + 1'b1;
               len_in   = len_ff - half_w - 1'b1;
            end else begin
               len_in   = half_w;
            end
            state_in = spi_pkg::S_SRCH_RD;
         end

         spi_pkg::S_SRCH_END: begin
            if (is_load) begin
               k_in     = count_ff;
               state_in = (count_ff == first_ff) ? spi_pkg::S_INSERT : spi_pkg::S_SHIFT_RD;
            end else if (first_ff >= count_ff) begin
               rd_addr  = last_w[spi_pkg::IDX_W-1:0];
               state_in = spi_pkg::S_OUT_ROW;
            end else if (first_ff == '0) begin
               rd_addr  = '0;
               state_in = spi_pkg::S_OUT_ROW;
            end else begin
               rd_addr  = im1_w[spi_pkg::IDX_W-1:0];
               state_in = spi_pkg::S_FETCH_LO;
            end
         end

         // move entries up one place to open the insertion slot
         spi_pkg::S_SHIFT_RD: begin
            rd_addr  = km1_w[spi_pkg::IDX_W-1:0];
            state_in = spi_pkg::S_SHIFT_WR;
         end

         spi_pkg::S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = k_ff[spi_pkg::IDX_W-1:0];
            wr_row   = rd_row_ff;
            k_in     = km1_w;
            state_in = (km1_w == first_ff) ? spi_pkg::S_INSERT : spi_pkg::S_SHIFT_RD;
         end

         spi_pkg::S_INSERT: begin
            wr_en          = 1'b1;
            wr_addr        = first_ff[spi_pkg::IDX_W-1:0];
            wr_row.p_time  = req_ff.in_time;
            wr_row.p_dist  = req_ff.in_dist;
            wr_row.p_speed = req_ff.in_speed;
            wr_row.p_accel = req_ff.in_accel;
            wr_row.p_jerk  = req_ff.in_jerk;
            count_in       = count_ff + 1'b1;
            emit           = 1'b1;
            emit_status    = spi_pkg::ST_DONE;
         end

         spi_pkg::S_OUT_ROW: begin
            emit        = 1'b1;
            emit_status = spi_pkg::ST_POINT;
            emit_pt     = rd_row_ff;
         end

         spi_pkg::S_FETCH_LO: begin
            lo_in    = rd_row_ff;
            rd_addr  = first_ff[spi_pkg::IDX_W-1:0];
            state_in = spi_pkg::S_FETCH_HI;
         end

         // alpha = (q - k0) * 2^F / (k1 - k0)
         spi_pkg::S_FETCH_HI: begin
            hi_in    = rd_row_ff;
            quo_in   = {lo_diff[31:0], {spi_pkg::FRAC_BITS{1'b0}}};
            rem_in   = '0;
            dvsr_in  = den_w[31:0];
            divc_in  = '0;
            ext_in   = 1'b0;
            state_in = spi_pkg::S_DIV;
         end

         // restoring divider, one quotient bit a cycle
         spi_pkg::S_DIV: begin
            rem_in  = div_ge ? rem_sub[31:0] : rem_sh[31:0];
            quo_in  = {quo_ff[spi_pkg::QUO_W-2:0], div_ge};
            divc_in = divc_ff + 1'b1;
            if (divc_ff == spi_pkg::DIVC_W'(spi_pkg::QUO_W - 1)) begin
               fld_in   = spi_pkg::FLD_TIME;
               state_in = ext_ff ? spi_pkg::S_EXT_FIN : spi_pkg::S_LERP_MUL;
            end
         end

         spi_pkg::S_LERP_MUL: begin
            mul_x    = {b_sub[32], b_sub};
            mul_y    = $signed({{(spi_pkg::MUL_YW - spi_pkg::ALPHA_W){1'b0}},
                                quo_ff[spi_pkg::ALPHA_W-1:0]});
            state_in = spi_pkg::S_LERP_ADD;
         end

         spi_pkg::S_LERP_ADD: begin
            pt_in  = lerp_pt;
            fld_in = fld_ff + 1'b1;
            if (fld_ff == spi_pkg::FLD_JERK) begin
               emit        = 1'b1;
               emit_status = spi_pkg::ST_POINT;
               emit_pt     = lerp_pt;
               if (by_dist) begin
                  emit_pt.p_dist = q;
               end else begin
                  emit_pt.p_time = q;
               end
            end else begin
               state_in = spi_pkg::S_LERP_MUL;
            end
         end

         spi_pkg::S_EXT_FIN: begin
            wsum           = spi_pkg::sx32(hi_ff.p_time) +
                             $signed({{(spi_pkg::WIDE_W - spi_pkg::QUO_W){1'b0}}, quo_ff});
            emit           = 1'b1;
            emit_status    = spi_pkg::ST_POINT;
            emit_pt.p_time = spi_pkg::sat32(wsum);
            emit_pt.p_dist = q;
            emit_pt.p_speed = pt_ff.p_speed;
         end

         // extrapolation: v + a*d, s + v*d + a*d*d/2, products one at a time
         spi_pkg::S_XP_MUL_A: begin
            mul_x    = {{2{hi_ff.p_accel[31]}}, hi_ff.p_accel};
            mul_y    = $signed({2'b00, d_ff});
            state_in = spi_pkg::S_XP_ADD_A;
         end

         spi_pkg::S_XP_ADD_A: begin
            p_in          = prod_ff[62:0];
            pt_in.p_speed = spi_pkg::sat32(spi_pkg::sx32(hi_ff.p_speed) +
                              spi_pkg::sxprod(prod_ff >>> spi_pkg::FRAC_BITS));
            state_in      = spi_pkg::S_XP_MUL_V;
         end

         spi_pkg::S_XP_MUL_V: begin
            mul_x    = {{2{hi_ff.p_speed[31]}}, hi_ff.p_speed};
            mul_y    = $signed({2'b00, d_ff});
            state_in = spi_pkg::S_XP_ADD_V;
         end

         spi_pkg::S_XP_ADD_V: begin
            acc_in   = spi_pkg::sx32(hi_ff.p_dist) +
                       spi_pkg::sxprod(prod_ff >>> spi_pkg::FRAC_BITS);
            state_in = spi_pkg::S_XP_MUL_L;
         end

         spi_pkg::S_XP_MUL_L: begin
            mul_x    = $signed({2'b00, p_ff[31:0]});
            mul_y    = $signed({2'b00, d_ff});
            state_in = spi_pkg::S_XP_MUL_H;
         end

         spi_pkg::S_XP_MUL_H: begin
            wide_in  = spi_pkg::sxprod(prod_ff);
            mul_x    = {{3{p_ff[62]}}, p_ff[62:32]};
            mul_y    = $signed({2'b00, d_ff});
            state_in = spi_pkg::S_XP_SUM;
         end

         spi_pkg::S_XP_SUM: begin
            wide_in  = wide_ff + (spi_pkg::sxprod(prod_ff) <<< 32);
            state_in = spi_pkg::S_XP_FIN;
         end

         spi_pkg::S_XP_FIN: begin
            wsum            = acc_ff + (wide_ff >>> (2 * spi_pkg::FRAC_BITS + 1));
            emit            = 1'b1;
            emit_status     = spi_pkg::ST_POINT;
            emit_pt.p_time  = q;
            emit_pt.p_dist  = spi_pkg::sat32(wsum);
            emit_pt.p_speed = pt_ff.p_speed;
            emit_pt.p_accel = hi_ff.p_accel;
         end

         default: state_in = spi_pkg::S_IDLE;
      endcase

      // every result closes the item and returns to idle
      if (emit) begin
         state_in = spi_pkg::S_IDLE;
      end
   end

   // result register: fields zero unless a point is returned
   always_comb begin
      rsp_valid_in = emit;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_in.status = emit_status;
         if (emit_status == spi_pkg::ST_POINT) begin
            rsp_in.out_time  = emit_pt.p_time;
            rsp_in.out_dist  = emit_pt.p_dist;
            rsp_in.out_speed = emit_pt.p_speed;
            rsp_in.out_accel = emit_pt.p_accel;
            rsp_in.out_jerk  = emit_pt.p_jerk;
         end else begin
            rsp_in.out_time  = '0;
            rsp_in.out_dist  = '0;
            rsp_in.out_speed = '0;
            rsp_in.out_accel = '0;
            rsp_in.out_jerk  = '0;
         end
      end
   end

   // an accepted item holds the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   // a result always closes its item
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result issued while still busy");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != spi_pkg::ST_POINT) |->
      (rsp_data.out_time == 32'sd0 && rsp_data.out_dist == 32'sd0 &&
       rsp_data.out_speed == 32'sd0 && rsp_data.out_accel == 32'sd0 &&
       rsp_data.out_jerk == 32'sd0))
      else $error("non-point result carries field data");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spi_pkg::CNT_W'(spi_pkg::TABLE_DEPTH))
      else $error("point count beyond table depth");

endmodule

/* bench/tb_speed_profile_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed profile interpolator testbench
// Drives clears, loads and time/distance queries through the command port,
// reprograms both limits between phases and checks every result item field
// by field against a typed answer or a bit-exact fixed-point predictor in the bench.
// ----------------------------------------------------------------------------
module tb_speed_profile_interpolator;
   import spi_pkg::*;

   localparam int  CLK_HALF   = 6;
   localparam int  RESET_CYC  = 12;
   localparam int  ITEM_GOAL  = 700;
   localparam int  SETTLE_CYC = 80;
   localparam int  CYCLE_CAP  = 1000000;
   localparam longint PROD_CLAMP = 64'sd1 <<< 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_XP_LIMIT;
   logic [31:0] csr_wdata = '0;

   speed_profile_interpolator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: the point table, its fill level and both limits
   // ------------------------------------------------------------------
   longint  tab_time  [TABLE_DEPTH];
   longint  tab_dist  [TABLE_DEPTH];
   longint  tab_speed [TABLE_DEPTH];
   longint  tab_accel [TABLE_DEPTH];
   longint  tab_jerk  [TABLE_DEPTH];
   int      tab_fill = 0;
   longint  xp_limit  = XP_LIMIT_RST;
   longint  ext_speed = MIN_SPEED_RST;

   rsp_type expected_items[$];
   int      fault_count = 0;
   int      cycle_count = 0;
   int      sent_items  = 0;

   // floor(x*y / 2^sh), clamped to +-2^60
   function automatic longint scaled_product(longint x, longint y, int sh);
      logic signed [127:0] xw, yw, p;
      xw = x;
      yw = y;
      p  = (xw * yw) >>> sh;
      if (p > PROD_CLAMP) p = PROD_CLAMP;
      if (p < -PROD_CLAMP) p = -PROD_CLAMP;
      return longint'(p[63:0]);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint blend(longint a, longint b, longint alpha);
      return clamp32(a + scaled_product(b - a, alpha, FRAC_BITS));
   endfunction

   function automatic longint key_at(int i, bit by_dist);
      return by_dist ? tab_dist[i] : tab_time[i];
   endfunction

   function automatic rsp_type point_item(longint t, longint s, longint v,
                                          longint a, longint j);
      rsp_type r;
      r.status    = ST_POINT;
      r.out_time  = clamp32(t);
      r.out_dist  = clamp32(s);
      r.out_speed = clamp32(v);
      r.out_accel = clamp32(a);
      r.out_jerk  = clamp32(j);
      return r;
   endfunction

   function automatic rsp_type stored_point(int i);
      return point_item(tab_time[i], tab_dist[i], tab_speed[i], tab_accel[i], tab_jerk[i]);
   endfunction

   // lower-bound search over the chosen key, then linear blend of the rest
   function automatic rsp_type bracket_blend(longint q, bit by_dist);
      int     first, len, half, mid;
      longint den, alpha, k0;
      first = 0;
      len   = tab_fill;
      while (len > 0) begin
         half = len / 2;
         mid  = first + half;
         if (key_at(mid, by_dist) < q) begin
            first = mid + 1;
            len   = len - half - 1;
         end else begin
            len = half;
         end
      end
      if (first >= tab_fill) return stored_point(tab_fill - 1);
      if (first == 0) return stored_point(0);
      k0  = key_at(first - 1, by_dist);
      den = key_at(first, by_dist) - k0;
      if (den <= 0) den = 1;
      alpha = ((q - k0) <<< FRAC_BITS) / den;
      return point_item(
         by_dist ? blend(tab_time[first-1], tab_time[first], alpha) : q,
         by_dist ? q : blend(tab_dist[first-1], tab_dist[first], alpha),
         blend(tab_speed[first-1], tab_speed[first], alpha),
         blend(tab_accel[first-1], tab_accel[first], alpha),
         blend(tab_jerk[first-1], tab_jerk[first], alpha));
   endfunction

   // Work out the answer to one command and advance the table.
   function automatic rsp_type profile_answer(req_type r);
      rsp_type    a;
      logic [2:0] c;
      longint     q, d, v, acc, nv, ns, dt;
      int         last, pos;
      a        = '0;
      a.status = ST_NONE;
      c        = r.command;
      q        = r.query_value;
      last     = (tab_fill > 0) ? tab_fill - 1 : 0;
      if (c == CMD_CLEAR) begin
         tab_fill = 0;
         a.status = ST_DONE;
         return a;
      end
      if (c == CMD_LOAD) begin
         if (tab_fill >= TABLE_DEPTH) begin
            a.status = ST_FULL;
            return a;
         end
         pos = 0;
         while (pos < tab_fill && tab_time[pos] <= longint'(r.in_time)) pos++;
         for (int k = tab_fill; k > pos; k--) begin
            tab_time[k]  = tab_time[k-1];
            tab_dist[k]  = tab_dist[k-1];
            tab_speed[k] = tab_speed[k-1];
            tab_accel[k] = tab_accel[k-1];
            tab_jerk[k]  = tab_jerk[k-1];
         end
         tab_time[pos]  = r.in_time;
         tab_dist[pos]  = r.in_dist;
         tab_speed[pos] = r.in_speed;
         tab_accel[pos] = r.in_accel;
         tab_jerk[pos]  = r.in_jerk;
         tab_fill++;
         a.status = ST_DONE;
         return a;
      end
      if (c > CMD_BY_DIST_EXT || tab_fill < 2) return a;
      if (c == CMD_BY_TIME || c == CMD_BY_TIME_XP) begin
         if (q < tab_time[0]) return a;
         if (q <= tab_time[last]) return bracket_blend(q, 1'b0);
         if (c == CMD_BY_TIME) return a;
         d = q - tab_time[last];
         if (d > xp_limit) return a;
         acc = tab_accel[last];
         v   = tab_speed[last];
         nv  = v + scaled_product(acc, d, FRAC_BITS);
         ns  = tab_dist[last] + scaled_product(v, d, FRAC_BITS)
               + scaled_product(acc * d, d, 2 * FRAC_BITS + 1);
         return point_item(q, ns, nv, acc, 0);
      end
      if (q < tab_dist[0]) return a;
      if (q > tab_dist[last]) begin
         if (c == CMD_BY_DIST) return a;
         v = (tab_speed[last] > ext_speed) ? tab_speed[last] : ext_speed;
         if (v <= 0) return a;
         dt = ((q - tab_dist[last]) <<< FRAC_BITS) / v;
         return point_item(tab_time[last] + dt, q, v, 0, 0);
      end
      return bracket_blend(q, 1'b1);
   endfunction

   // ------------------------------------------------------------------
   // Result checker: every strobed item must match the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("speed_profile_interpolator verification failed");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (expected_items.size() == 0) begin
            $error("result item with nothing expected");
            fault_count <= fault_count + 1;
         end else begin
            want = expected_items.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fault_count <= fault_count + 1;
            end
            if (rsp_data.out_time !== want.out_time) begin
               $error("out_time: expected %0d, got %0d", want.out_time, rsp_data.out_time);
               fault_count <= fault_count + 1;
            end
            if (rsp_data.out_dist !== want.out_dist) begin
               $error("out_dist: expected %0d, got %0d", want.out_dist, rsp_data.out_dist);
               fault_count <= fault_count + 1;
            end
            if (rsp_data.out_speed !== want.out_speed) begin
               $error("out_speed: expected %0d, got %0d", want.out_speed, rsp_data.out_speed);
               fault_count <= fault_count + 1;
            end
            if (rsp_data.out_accel !== want.out_accel) begin
               $error("out_accel: expected %0d, got %0d", want.out_accel, rsp_data.out_accel);
               fault_count <= fault_count + 1;
            end
            if (rsp_data.out_jerk !== want.out_jerk) begin
               $error("out_jerk: expected %0d, got %0d", want.out_jerk, rsp_data.out_jerk);
               fault_count <= fault_count + 1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } plan_row;

   plan_row plan[$];

   function automatic req_type make_req(logic [2:0] c, logic [31:0] t, logic [31:0] s,
                                        logic [31:0] v, logic [31:0] a, logic [31:0] j,
                                        logic [31:0] q);
      req_type r;
      r.command     = cmd_type'(c);
      r.in_time     = t;
      r.in_dist     = s;
      r.in_speed    = v;
      r.in_accel    = a;
      r.in_jerk     = j;
      r.query_value = q;
      return r;
   endfunction

   function automatic rsp_type make_rsp(status_type st, logic [31:0] t, logic [31:0] s,
                                        logic [31:0] v, logic [31:0] a, logic [31:0] j);
      rsp_type r;
      r.status    = st;
      r.out_time  = t;
      r.out_dist  = s;
      r.out_speed = v;
      r.out_accel = a;
      r.out_jerk  = j;
      return r;
   endfunction

   function automatic logic [31:0] rand_word();
      return $urandom;
   endfunction

   // Hold the item on the port until it is taken, queue its answer, then
   // drop start for the drawn gap (keep start high when the gap is zero).
   task automatic issue(req_type r, bit typed, rsp_type want, int gap);
      rsp_type guess;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      guess = profile_answer(r);
      expected_items.push_back(typed ? want : guess);
      sent_items++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Let every outstanding item come back before touching the registers.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (expected_items.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic idx, logic [30:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= {1'b0, value};
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_XP_LIMIT) xp_limit = value;
      else ext_speed = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [30:0] pick_limit();
      case ($urandom_range(0, 4))
         0:       return 31'd0;
         1:       return 31'h7FFF_FFFF;
         2:       return $urandom_range(0, 32'h0010_0000);
         3:       return $urandom;
         default: return $urandom_range(0, 32'h0008_0000);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      rsp_type       none_item, done_item;
      req_type       r;
      bit            calm;
      int            npts, nq, gap, idx, tmp;
      longint        t_now, s_now, lo, hi, margin, span, q;
      bit            by_dist;
      logic [2:0]    c;
      logic [31:0]   pt_t [$];
      logic [31:0]   pt_s [$];

      none_item = make_rsp(ST_NONE, 0, 0, 0, 0, 0);
      done_item = make_rsp(ST_DONE, 0, 0, 0, 0, 0);

      // Directed table: typed answers only where they are obvious.
      plan.push_back('{make_req(CMD_BY_TIME, 0, 0, 0, 0, 0, 0), 1, none_item});
      plan.push_back('{make_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 1, done_item});
      plan.push_back('{make_req(CMD_LOAD, 0, 0, 32'h1_0000, 0, 0, 0), 1, done_item});
      // a single point answers nothing
      plan.push_back('{make_req(CMD_BY_TIME, 0, 0, 0, 0, 0, 0), 1, none_item});
      plan.push_back('{make_req(CMD_LOAD, 32'hA_0000, 32'h14_0000, 32'h3_0000,
                                32'h0_8000, 32'hFFFF_0000, 0), 1, done_item});
      // equal time goes after the existing point
      plan.push_back('{make_req(CMD_LOAD, 32'hA_0000, 32'h1E_0000, 32'h2_0000,
                                32'hFFFF_8000, 32'h1_0000, 0), 1, done_item});
      // search landing on the first entry returns it as stored
      plan.push_back('{make_req(CMD_BY_TIME, 0, 0, 0, 0, 0, 0), 1,
                       make_rsp(ST_POINT, 0, 0, 32'h1_0000, 0, 0)});
      plan.push_back('{make_req(CMD_BY_TIME, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, none_item});
      plan.push_back('{make_req(CMD_BY_TIME, 0, 0, 0, 0, 0, 32'h5_4321), 0, none_item});
      plan.push_back('{make_req(CMD_BY_TIME, 0, 0, 0, 0, 0, 32'hA_0000), 0, none_item});
      plan.push_back('{make_req(CMD_BY_TIME, 0, 0, 0, 0, 0, 32'hC_0000), 1, none_item});
      plan.push_back('{make_req(CMD_BY_TIME_XP, 0, 0, 0, 0, 0, 32'hC_0000), 0, none_item});
      // just past the extrapolation limit
      plan.push_back('{make_req(CMD_BY_TIME_XP, 0, 0, 0, 0, 0, 32'hF_0001), 1, none_item});
      plan.push_back('{make_req(CMD_BY_TIME_XP, 0, 0, 0, 0, 0, 32'hF_0000), 0, none_item});
      plan.push_back('{make_req(CMD_BY_DIST, 0, 0, 0, 0, 0, 32'h9_8765), 0, none_item});
      plan.push_back('{make_req(CMD_BY_DIST, 0, 0, 0, 0, 0, 32'h8000_0000), 1, none_item});
      plan.push_back('{make_req(CMD_BY_DIST, 0, 0, 0, 0, 0, 32'h28_0000), 1, none_item});
      plan.push_back('{make_req(CMD_BY_DIST_EXT, 0, 0, 0, 0, 0, 32'h28_0000), 0, none_item});
      plan.push_back('{make_req(CMD_BY_DIST_EXT, 0, 0, 0, 0, 0, 32'h7FFF_FFFF), 0, none_item});
      // unused command codes
      plan.push_back('{make_req(3'd6, '1, '1, '1, '1, '1, '1), 1, none_item});
      plan.push_back('{make_req(3'd7, 0, 0, 0, 0, 0, 0), 1, none_item});
      // field extremes
      plan.push_back('{make_req(CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000, 0), 1, done_item});
      plan.push_back('{make_req(CMD_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 1, done_item});
      plan.push_back('{make_req(CMD_BY_TIME_XP, 0, 0, 0, 0, 0, 32'h7FFF_FFFF), 0, none_item});
      plan.push_back('{make_req(CMD_BY_DIST, 0, 0, 0, 0, 0, 32'h1234_5678), 0, none_item});

      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) issue(plan[i].item, plan[i].typed, plan[i].want, $urandom_range(0, 17));

      // Fill to the brim; the last load must bounce with table full.
      for (int i = 0; i < TABLE_DEPTH; i++)
         issue(make_req(CMD_LOAD, $urandom_range(0, 32'h40_0000), rand_word(), rand_word(),
                        rand_word(), rand_word(), 0), 0, none_item, 0);
      issue(make_req(CMD_LOAD, 0, 0, 0, 0, 0, 0), 1, make_rsp(ST_FULL, 0, 0, 0, 0, 0), 0);

      // Random phases: new limits, then a well-formed profile and queries on it.
      while (sent_items < ITEM_GOAL) begin
         drain();
         if ($urandom_range(0, 1)) write_limit(CSR_XP_LIMIT, pick_limit());
         if ($urandom_range(0, 1)) write_limit(CSR_MIN_SPEED, pick_limit());
         calm = ($urandom_range(0, 2) == 0);

         npts  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 8);
         t_now = $signed($urandom_range(0, 32'h0100_0000)) - 64'sh80_0000;
         s_now = $signed($urandom_range(0, 32'h0100_0000)) - 64'sh80_0000;
         pt_t.delete();
         pt_s.delete();
         for (int i = 0; i < npts; i++) begin
            pt_t.push_back(clamp32(t_now));
            pt_s.push_back(clamp32(s_now));
            t_now += ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 32'h4_0000);
            s_now += ($urandom_range(0, 7) == 0) ? -$urandom_range(0, 32'h1_0000)
                                                 : $urandom_range(0, 32'h8_0000);
         end
         // load out of order so the sorted insert is exercised
         for (int i = pt_t.size() - 1; i > 0; i--) begin
            idx = $urandom_range(0, i);
            tmp = pt_t[i]; pt_t[i] = pt_t[idx]; pt_t[idx] = tmp;
         end
         issue(make_req(CMD_CLEAR, rand_word(), 0, 0, 0, 0, rand_word()), 0, none_item,
               calm ? 0 : $urandom_range(0, 17));
         foreach (pt_t[i])
            issue(make_req(CMD_LOAD, pt_t[i], pt_s[i],
                           $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0004_0000,
                           $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                           $urandom_range(0, 1) ? rand_word() : 32'd0, rand_word()),
                  0, none_item, calm ? 0 : $urandom_range(0, 17));

         nq = $urandom_range(20, 60);
         for (int i = 0; i < nq; i++) begin
            gap = calm ? 0 : $urandom_range(0, 17);
            c   = $urandom_range(CMD_BY_TIME, CMD_BY_DIST_EXT);
            case ($urandom_range(0, 19))
               0: r = make_req($urandom_range(6, 7), rand_word(), rand_word(), rand_word(),
                               rand_word(), rand_word(), rand_word());
               1: r = make_req(CMD_LOAD, rand_word(), rand_word(), rand_word(),
                               rand_word(), rand_word(), rand_word());
               2: r = make_req(c, rand_word(), rand_word(), rand_word(),
                               rand_word(), rand_word(), rand_word());
               default: begin
                  by_dist = (c >= CMD_BY_DIST);
                  if (tab_fill > 0) begin
                     lo = key_at(0, by_dist);
                     hi = key_at(tab_fill - 1, by_dist);
                  end else begin
                     lo = 0;
                     hi = 0;
                  end
                  if (hi < lo) hi = lo;
                  margin = (hi - lo) / 4 + 64'sh8_0000;
                  span   = hi - lo + 2 * margin + 1;
                  q      = lo - margin + longint'({$urandom, $urandom} % span);
                  r = make_req(c, rand_word(), rand_word(), rand_word(), rand_word(),
                               rand_word(), clamp32(q));
               end
            endcase
            issue(r, 0, none_item, gap);
         end
      end

      // Wind down: let the last results arrive, then allow the settle time.
      drain();
      repeat (SETTLE_CYC) @(posedge clock);
      if (fault_count == 0 && expected_items.size() == 0) begin
         $display("speed_profile_interpolator verification clean");
      end else begin
         $display("speed_profile_interpolator verification failed");
      end
      $finish;
   end

endmodule
